// File: rtl/core/assert_macros.svh
// assertion macros used by the port checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define LZ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lztbf assertion failed");

// next-cycle implication, disabled while reset is low
`define LZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lztbf assertion failed");

`endif

// File: rtl/core/lztbf_pkg.sv
// types, token codes and match decode for the two-bit-flag lzss decoder
// no dependencies
package lztbf_pkg;

    localparam int LEN_W  = 10;
    localparam int DIST_W = 16;

    localparam logic [1:0] KIND_LITERAL = 2'd0;
    localparam logic [1:0] KIND_SHORT   = 2'd1;
    localparam logic [1:0] KIND_MEDIUM  = 2'd2;
    localparam logic [1:0] KIND_LONG    = 2'd3;

    localparam logic [2:0] FLAGS_PER_BYTE = 3'd4;
    localparam logic [4:0] CHUNK_BYTES    = 5'd16;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_start;
    } t_in_req;

    typedef struct packed {
        logic [63:0] chunk_low;
        logic [63:0] chunk_high;
        logic [4:0]  byte_count;
        logic        bad_distance;
        logic        run_end;
    } t_out_req;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [DIST_W-1:0] distance;
    } t_match;

    function automatic t_match decode_match(input logic [1:0] kind, input logic [23:0] c);
        t_match m;
        case (kind)
            KIND_SHORT: begin
                m.len      = LEN_W'(c[1:0]) + LEN_W'(2);
                m.distance = DIST_W'(c[7:2]) + DIST_W'(1);
            end
            KIND_MEDIUM: begin
                m.len      = LEN_W'(c[5:0]) + LEN_W'(3);
                m.distance = DIST_W'(c[15:6]) + DIST_W'(1);
            end
            default: begin
                m.len      = LEN_W'(c[8:0]) + LEN_W'(4);
                m.distance = DIST_W'(c[23:9]) + DIST_W'(1);
            end
        endcase
        return m;
    endfunction

endpackage

// File: rtl/core/lzss_two_bit_flag_decoder.sv
// two-bit-flag lzss decoder top level: parser, history window and copy sequencer
// depends on lztbf_pkg
//
// One compressed byte is taken per request while the block is idle. Flag bytes and
// pending control bytes give no result and leave the block idle. A literal is
// written to the window and handed to the result register. A match passes a
// distance check, then copies each byte through the single read port of the
// history window (address, then registered data written back) and hands each chunk
// of up to 16 bytes to the result register, waiting there while the result side
// stalls. A distance beyond the bytes produced so far gives one error result. The
// result register lets the last result wait while the next byte is taken. The
// window needs no clearing after reset.
module lzss_two_bit_flag_decoder
    import lztbf_pkg::*;
#(
    parameter int WINDOW_BYTES = 32768
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_req  i_in_req,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_out_req o_out_req
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int PW = $clog2(WINDOW_BYTES + 1);
    localparam int CW = (PW > DIST_W) ? PW : DIST_W;
    localparam int WRAP = WINDOW_BYTES - 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_WRITE = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]        r_state, n_state;
    logic [7:0]        r_flag_bits, n_flag_bits;
    logic [2:0]        r_flags_left, n_flags_left;
    logic [1:0]        r_token_kind, n_token_kind;
    logic [1:0]        r_ctrl_need, n_ctrl_need;
    logic [15:0]       r_ctrl_acc, n_ctrl_acc;
    logic [AW-1:0]     r_wp, n_wp;
    logic [PW-1:0]     r_produced, n_produced;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [DIST_W-1:0] r_dist, n_dist;
    logic [127:0]      r_chunk, n_chunk;
    logic [4:0]        r_cnt, n_cnt;
    logic              r_last, n_last;
    logic              r_bad, n_bad;
    t_out_req          r_out, n_out;
    logic              r_out_valid, n_out_valid;

    logic [7:0]        r_hist [WINDOW_BYTES];
    logic [7:0]        r_hist_q;

    logic              in_acc;
    logic              e_start;
    logic [7:0]        e_flag_bits;
    logic [2:0]        e_flags_left;
    logic [1:0]        e_token_kind;
    logic [1:0]        e_ctrl_need;
    logic [15:0]       e_ctrl_acc;
    logic [AW-1:0]     e_wp;
    logic [PW-1:0]     e_produced;
    logic [AW-1:0]     wp_inc;
    logic [PW-1:0]     produced_inc;
    logic [AW:0]       src_diff;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [7:0]        mem_wdata;
    logic [1:0]        kind;
    t_match            m;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    // stream start clears the parser and history count before this byte is used
    assign e_start      = in_acc && i_in_req.stream_start;
    assign e_flag_bits  = e_start ? '0 : r_flag_bits;
    assign e_flags_left = e_start ? '0 : r_flags_left;
    assign e_token_kind = e_start ? '0 : r_token_kind;
    assign e_ctrl_need  = e_start ? '0 : r_ctrl_need;
    assign e_ctrl_acc   = e_start ? '0 : r_ctrl_acc;
    assign e_wp         = e_start ? '0 : r_wp;
    assign e_produced   = e_start ? '0 : r_produced;

    assign wp_inc       = (e_wp == AW'(WRAP)) ? '0 : e_wp + AW'(1);
    assign produced_inc = (e_produced == PW'(WINDOW_BYTES)) ? e_produced
                                                            : e_produced + PW'(1);

    // copy source, wrapped back into the window
    assign src_diff = {1'b0, r_wp} - (AW+1)'(r_dist);
    assign rd_addr  = src_diff[AW] ? AW'(src_diff + (AW+1)'(WINDOW_BYTES))
                                   : src_diff[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[e_wp] <= mem_wdata;
        end
        r_hist_q <= r_hist[rd_addr];
    end

    always_comb begin
        n_state      = r_state;
        n_flag_bits  = e_flag_bits;
        n_flags_left = e_flags_left;
        n_token_kind = e_token_kind;
        n_ctrl_need  = e_ctrl_need;
        n_ctrl_acc   = e_ctrl_acc;
        n_wp         = e_wp;
        n_produced   = e_produced;
        n_len        = r_len;
        n_dist       = r_dist;
        n_chunk      = r_chunk;
        n_cnt        = r_cnt;
        n_last       = r_last;
        n_bad        = r_bad;
        n_out        = r_out;
        n_out_valid  = r_out_valid && !i_out_ready;
        mem_we       = 1'b0;
        mem_wdata    = i_in_req.in_byte;
        kind         = e_flag_bits[1:0];
        m            = decode_match(e_token_kind, {e_ctrl_acc, i_in_req.in_byte});

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (e_ctrl_need != 2'd0) begin
                        n_ctrl_need = e_ctrl_need - 2'd1;
                        if (e_ctrl_need != 2'd1) begin
                            n_ctrl_acc = {e_ctrl_acc[7:0], i_in_req.in_byte};
                        end else begin
                            n_len      = m.len;
                            n_dist     = m.distance;
                            n_ctrl_acc = '0;
                            n_state    = ST_CHECK;
                        end
                    end else if (e_flags_left == 3'd0) begin
                        n_flag_bits  = i_in_req.in_byte;
                        n_flags_left = FLAGS_PER_BYTE;
                    end else begin
                        n_flag_bits  = {2'b00, e_flag_bits[7:2]};
                        n_flags_left = e_flags_left - 3'd1;
                        n_token_kind = kind;
                        case (kind)
                            KIND_LITERAL: begin
                                mem_we     = 1'b1;
                                n_wp       = wp_inc;
                                n_produced = produced_inc;
                                n_chunk    = 128'(i_in_req.in_byte);
                                n_cnt      = 5'd1;
                                n_last     = 1'b1;
                                n_bad      = 1'b0;
                                n_state    = ST_EMIT;
                            end
                            KIND_SHORT: begin
                                m       = decode_match(KIND_SHORT,
                                                       {16'h0000, i_in_req.in_byte});
                                n_len   = m.len;
                                n_dist  = m.distance;
                                n_state = ST_CHECK;
                            end
                            default: begin
                                n_ctrl_acc  = {8'h00, i_in_req.in_byte};
                                n_ctrl_need = kind - 2'd1;
                            end
                        endcase
                    end
                end
            end
            ST_CHECK: begin
                if (CW'(r_dist) > CW'(r_produced)) begin
                    n_bad   = 1'b1;
                    n_last  = 1'b1;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                mem_we     = 1'b1;
                mem_wdata  = r_hist_q;
                n_wp       = wp_inc;
                n_produced = produced_inc;
                n_chunk[{r_cnt[3:0], 3'b000} +: 8] = r_hist_q;
                n_cnt      = r_cnt + 5'd1;
                n_len      = r_len - LEN_W'(1);
                if (r_len == LEN_W'(1) || r_cnt == CHUNK_BYTES - 5'd1) begin
                    n_last  = (r_len == LEN_W'(1));
                    n_bad   = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.chunk_low    = r_chunk[63:0];
                    n_out.chunk_high   = r_chunk[127:64];
                    n_out.byte_count   = r_bad ? 5'd0 : r_cnt;
                    n_out.bad_distance = r_bad;
                    n_out.run_end      = r_last;
                    n_out_valid        = 1'b1;
                    n_chunk            = '0;
                    n_cnt              = '0;
                    n_state            = r_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_flag_bits  <= '0;
            r_flags_left <= '0;
            r_token_kind <= '0;
            r_ctrl_need  <= '0;
            r_ctrl_acc   <= '0;
            r_wp         <= '0;
            r_produced   <= '0;
            r_chunk      <= '0;
            r_cnt        <= '0;
            r_last       <= 1'b0;
            r_bad        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_flag_bits  <= n_flag_bits;
            r_flags_left <= n_flags_left;
            r_token_kind <= n_token_kind;
            r_ctrl_need  <= n_ctrl_need;
            r_ctrl_acc   <= n_ctrl_acc;
            r_wp         <= n_wp;
            r_produced   <= n_produced;
            r_chunk      <= n_chunk;
            r_cnt        <= n_cnt;
            r_last       <= n_last;
            r_bad        <= n_bad;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len  <= n_len;
        r_dist <= n_dist;
        r_out  <= n_out;
    end

endmodule

// File: rtl/core/lztbf_checker.sv
// port checker for the two-bit-flag lzss decoder, bound to the top level
// depends on lztbf_pkg and assert_macros.svh
`include "assert_macros.svh"

module lztbf_checker
    import lztbf_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_out_req o_out_req
);

    logic bad_out;
    logic good_out;
    logic partial_out;
    logic bad_shape_ok;

    assign bad_out      = o_out_valid && o_out_req.bad_distance;
    assign good_out     = o_out_valid && !o_out_req.bad_distance;
    assign partial_out  = good_out && (o_out_req.byte_count != CHUNK_BYTES);
    assign bad_shape_ok = (o_out_req.byte_count == 5'd0) && o_out_req.run_end
                          && (o_out_req.chunk_low == 64'd0) && (o_out_req.chunk_high == 64'd0);

    `LZ_ASSERT_NOW(a_count_max, i_clk, i_rst_n, o_out_valid, o_out_req.byte_count <= CHUNK_BYTES)
    `LZ_ASSERT_NOW(a_bad_shape, i_clk, i_rst_n, bad_out, bad_shape_ok)
    `LZ_ASSERT_NOW(a_good_nonempty, i_clk, i_rst_n, good_out, o_out_req.byte_count != 5'd0)
    `LZ_ASSERT_NOW(a_partial_is_last, i_clk, i_rst_n, partial_out, o_out_req.run_end)
    `LZ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_req))

endmodule

bind lzss_two_bit_flag_decoder lztbf_checker u_lztbf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req)
);
